/* rtl/core/tsu_pkg.sv */
// ----------------------------------------------------------------------------
// tsu_pkg
// Shared widths, the reciprocal table and the item record that moves along
// the Taylor sine pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tsu_pkg;

  localparam int FRAC_BITS = 28;
  localparam int ANGLE_W   = 31;
  localparam int SINE_W    = 36;
  localparam int CNT_W     = 4;

  // Magnitude widths follow from |x| <= 4: x2 <= 16, |term| < 11, |p| < 176.
  localparam int XMAG_W = ANGLE_W;
  localparam int MAG_W  = 32;
  localparam int X2_W   = 33;
  localparam int P_W    = 36;
  localparam int RCP_W  = 26;
  localparam int SUM_W  = SINE_W + 2;

  localparam logic [CNT_W-1:0] TERM_COUNT_RST = 4'd6;

  localparam int RCP_DEPTH = 16;

  // floor(2^28 / ((2i)(2i+1))); entry zero is never used.
  localparam logic [RCP_W-1:0] RCP_TABLE [RCP_DEPTH] = '{
    26'd0,        26'd44739242, 26'd13421772, 26'd6391320,
    26'd3728270,  26'd2440322,  26'd1720740,  26'd1278264,
    26'd986895,   26'd784898,   26'd639132,   26'd530504,
    26'd447392,   26'd382386,   26'd330585,   26'd288640
  };

  localparam logic signed [SUM_W-1:0] SINE_MAX = SUM_W'((64'sd1 <<< (SINE_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SINE_MIN = SUM_W'(-(64'sd1 <<< (SINE_W - 1)));

  // One item in flight: the current term as sign and magnitude, and the
  // sum of the terms before it.
  typedef struct packed {
    logic [CNT_W-1:0]         n;
    logic [X2_W-1:0]          x2;
    logic                     sign;
    logic [MAG_W-1:0]         mag;
    logic signed [SUM_W-1:0]  sum;
  } tsu_item_t;

  function automatic logic signed [SUM_W-1:0] tsu_term_value(input logic sign,
                                                            input logic [MAG_W-1:0] mag);
    logic signed [SUM_W-1:0] ext;
    ext = SUM_W'({1'b0, mag});
    return sign ? -ext : ext;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tsu_square.sv */
// ----------------------------------------------------------------------------
// tsu_square
// Front of the pipeline: takes the request, splits the angle into sign and
// magnitude, then squares it to form x2; the magnitude is the first term.
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_square #(
  parameter int MAX_TERMS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [tsu_pkg::ANGLE_W-1:0] in_angle,
  input  wire logic [tsu_pkg::CNT_W-1:0]     term_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output tsu_pkg::tsu_item_t                 out_item
);
  import tsu_pkg::*;

  logic                   a_vld_r;
  logic                   a_sign_r;
  logic [XMAG_W-1:0]      a_mag_r;
  logic [CNT_W-1:0]       a_n_r;
  logic                   b_vld_r;
  tsu_item_t              b_item_r;
  logic                   a_rdy;
  logic                   b_rdy;
  logic [CNT_W-1:0]       n_nxt;
  logic [XMAG_W-1:0]      mag_nxt;
  logic [2*XMAG_W-1:0]    sq;
  tsu_item_t              b_item_nxt;

  assign b_rdy    = !b_vld_r || out_ready;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  always_comb begin
    if ({1'b0, term_count} > (CNT_W + 1)'(MAX_TERMS)) begin
      n_nxt = CNT_W'(MAX_TERMS);
    end else begin
      n_nxt = term_count;
    end
    mag_nxt = in_angle[ANGLE_W-1] ? XMAG_W'(-in_angle) : XMAG_W'(in_angle);
  end

  always_comb begin
    sq               = a_mag_r * a_mag_r;
    b_item_nxt.n     = a_n_r;
    b_item_nxt.x2    = sq[FRAC_BITS +: X2_W];
    b_item_nxt.sign  = a_sign_r;
    b_item_nxt.mag   = MAG_W'(a_mag_r);
    b_item_nxt.sum   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= in_valid;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_sign_r <= in_angle[ANGLE_W-1];
      a_mag_r  <= mag_nxt;
      a_n_r    <= n_nxt;
    end
    if (a_vld_r && b_rdy) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign out_valid = b_vld_r;
  assign out_item  = b_item_r;

endmodule

`default_nettype wire

/* rtl/core/tsu_term_stage.sv */
// ----------------------------------------------------------------------------
// tsu_term_stage
// One series step: adds the incoming term to the sum if it counts, multiplies
// it by x2, then scales by the reciprocal of (2i)(2i+1) and flips the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_term_stage #(
  parameter int TERM_IDX = 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tsu_pkg::tsu_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tsu_pkg::tsu_item_t      out_item
);
  import tsu_pkg::*;

  localparam logic [CNT_W:0]       PREV_IDX = (CNT_W + 1)'(TERM_IDX - 1);
  localparam logic [RCP_W-1:0]     RCP      = RCP_TABLE[TERM_IDX];

  logic                     a_vld_r;
  logic [CNT_W-1:0]         a_n_r;
  logic [X2_W-1:0]          a_x2_r;
  logic                     a_sign_r;
  logic [P_W-1:0]           a_p_r;
  logic signed [SUM_W-1:0]  a_sum_r;
  logic                     b_vld_r;
  tsu_item_t                b_item_r;
  logic                     a_rdy;
  logic                     b_rdy;
  logic [MAG_W+X2_W-1:0]    prod_a;
  logic [P_W+RCP_W-1:0]     prod_b;
  logic signed [SUM_W-1:0]  sum_nxt;
  tsu_item_t                b_item_nxt;

  assign b_rdy    = !b_vld_r || out_ready;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  always_comb begin
    prod_a = in_item.mag * in_item.x2;
    // The previous term counts only if it is among the first n terms.
    if (PREV_IDX < {1'b0, in_item.n}) begin
      sum_nxt = in_item.sum + tsu_term_value(in_item.sign, in_item.mag);
    end else begin
      sum_nxt = in_item.sum;
    end
  end

  always_comb begin
    prod_b          = a_p_r * RCP;
    b_item_nxt.n    = a_n_r;
    b_item_nxt.x2   = a_x2_r;
    b_item_nxt.sign = !a_sign_r;
    b_item_nxt.mag  = prod_b[FRAC_BITS +: MAG_W];
    b_item_nxt.sum  = a_sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= in_valid;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_n_r    <= in_item.n;
      a_x2_r   <= in_item.x2;
      a_sign_r <= in_item.sign;
      a_p_r    <= prod_a[FRAC_BITS +: P_W];
      a_sum_r  <= sum_nxt;
    end
    if (a_vld_r && b_rdy) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign out_valid = b_vld_r;
  assign out_item  = b_item_r;

endmodule

`default_nettype wire

/* rtl/core/tsu_output.sv */
// ----------------------------------------------------------------------------
// tsu_output
// Tail of the pipeline: adds the last term if it counts, clamps the sum to
// the output range and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_output #(
  parameter int MAX_TERMS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire tsu_pkg::tsu_item_t           in_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [tsu_pkg::SINE_W-1:0] out_sine,
  output logic                              out_saturated
);
  import tsu_pkg::*;

  localparam logic [CNT_W:0] LAST_IDX = (CNT_W + 1)'(MAX_TERMS - 1);

  logic                     a_vld_r;
  logic signed [SUM_W-1:0]  a_sum_r;
  logic                     b_vld_r;
  logic signed [SINE_W-1:0] b_sine_r;
  logic                     b_sat_r;
  logic                     a_rdy;
  logic                     b_rdy;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SINE_W-1:0] sine_nxt;
  logic                     sat_nxt;

  assign b_rdy    = !b_vld_r || out_ready;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  always_comb begin
    if (LAST_IDX < {1'b0, in_item.n}) begin
      sum_nxt = in_item.sum + tsu_term_value(in_item.sign, in_item.mag);
    end else begin
      sum_nxt = in_item.sum;
    end
  end

  always_comb begin
    if (a_sum_r > SINE_MAX) begin
      sine_nxt = SINE_MAX[SINE_W-1:0];
      sat_nxt  = 1'b1;
    end else if (a_sum_r < SINE_MIN) begin
      sine_nxt = SINE_MIN[SINE_W-1:0];
      sat_nxt  = 1'b1;
    end else begin
      sine_nxt = a_sum_r[SINE_W-1:0];
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= in_valid;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_sum_r <= sum_nxt;
    end
    if (a_vld_r && b_rdy) begin
      b_sine_r <= sine_nxt;
      b_sat_r  <= sat_nxt;
    end
  end

  assign out_valid     = b_vld_r;
  assign out_sine      = b_sine_r;
  assign out_saturated = b_sat_r;

endmodule

`default_nettype wire

/* rtl/core/taylor_sine_unit.sv */
// ----------------------------------------------------------------------------
// taylor_sine_unit
// Throughput: one angle per cycle while the output is not stalled; each
// series step owns its two multipliers.
// Every stage holds its own valid bit, so bubbles are absorbed under stall.
// Reset (rst_n, synchronous): empties the pipeline and sets term_count to 6.
// ----------------------------------------------------------------------------
`default_nettype none

module taylor_sine_unit #(
  parameter int MAX_TERMS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [tsu_pkg::CNT_W-1:0]         cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [tsu_pkg::ANGLE_W-1:0] in_angle,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [tsu_pkg::SINE_W-1:0]      out_sine,
  output logic                                   out_saturated
);
  import tsu_pkg::*;

  logic [CNT_W-1:0] term_count_r;
  tsu_item_t        item   [MAX_TERMS];
  logic             vld    [MAX_TERMS];
  logic             rdy    [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= TERM_COUNT_RST;
    end else if (cfg_we) begin
      term_count_r <= cfg_wdata;
    end
  end

  tsu_square #(
    .MAX_TERMS (MAX_TERMS)
  ) u_square (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_angle   (in_angle),
    .term_count (term_count_r),
    .out_valid  (vld[0]),
    .out_ready  (rdy[0]),
    .out_item   (item[0])
  );

  // One step per series term after the first.
  for (genvar i = 1; i < MAX_TERMS; i++) begin : g_term
    tsu_term_stage #(
      .TERM_IDX (i)
    ) u_term (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[i-1]),
      .in_ready  (rdy[i-1]),
      .in_item   (item[i-1]),
      .out_valid (vld[i]),
      .out_ready (rdy[i]),
      .out_item  (item[i])
    );
  end

  tsu_output #(
    .MAX_TERMS (MAX_TERMS)
  ) u_output (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (vld[MAX_TERMS-1]),
    .in_ready      (rdy[MAX_TERMS-1]),
    .in_item       (item[MAX_TERMS-1]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sine      (out_sine),
    .out_saturated (out_saturated)
  );

endmodule

`default_nettype wire

/* tb/taylor_sine_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sine_unit_tb
// Self-checking bench for the pipelined Taylor sine unit. Angles go in
// through a valid/ready channel. A bit-accurate predictor works out each
// partial series sum at the term count in force when the angle is taken.
// Results are checked in order, with random stalls on both channels, a
// long output hold and a sweep over every term count.
// ----------------------------------------------------------------------------

module taylor_sine_unit_tb;
  import tsu_pkg::*;

  localparam int MAX_TERMS      = 12;
  localparam int LATENCY        = 2 * MAX_TERMS + 2;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_ONE = 31'sd268435456;
  localparam logic signed [ANGLE_W-1:0] ANGLE_THREE = 31'sd805306368;
  localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = 31'sd421657428;
  localparam logic signed [ANGLE_W-1:0] ANGLE_PI = 31'sd843314856;

  localparam longint SINE_HI = (longint'(1) <<< (SINE_W - 1)) - 1;
  localparam longint SINE_LO = -(longint'(1) <<< (SINE_W - 1));
  localparam logic [127:0] MAG_LIMIT = 128'd1 << 56;

  typedef struct packed {
    logic signed [SINE_W-1:0] sine;
    logic                     saturated;
  } sine_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CNT_W-1:0]          cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] in_angle = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SINE_W-1:0]  out_sine;
  logic                      out_saturated;

  sine_result_t     expected_sines[$];
  logic [CNT_W-1:0] terms_cfg = TERM_COUNT_RST;
  bit               idle_enable = 1'b1;
  bit               hold_out = 1'b0;
  int               mismatches = 0;
  int               angles_sent = 0;
  int               results_checked = 0;
  int               quiet_cycles = 0;

  taylor_sine_unit #(
    .MAX_TERMS(MAX_TERMS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_angle     (in_angle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sine     (out_sine),
    .out_saturated(out_saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Signed fixed-point product, truncated toward zero, magnitude capped.
  function automatic longint fix_mul(input longint a, input longint b);
    logic [127:0] full;
    logic [63:0]  ma, mb, mag;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    full = ({64'd0, ma} * {64'd0, mb}) >> FRAC_BITS;
    mag = (full > MAG_LIMIT) ? MAG_LIMIT[63:0] : full[63:0];
    return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic sine_result_t taylor_predict(input logic signed [ANGLE_W-1:0] angle,
                                                  input logic [CNT_W-1:0] terms);
    sine_result_t res;
    int           n;
    longint       x, x2, term, prod, recip, sum;
    n = (terms > MAX_TERMS) ? MAX_TERMS : terms;
    x = angle;
    x2 = fix_mul(x, x);
    sum = 0;
    term = x;
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        recip = (longint'(1) <<< FRAC_BITS) / ((2 * i) * (2 * i + 1));
        prod = fix_mul(term, x2);
        term = -fix_mul(prod, recip);
      end
      sum += term;
    end
    res.saturated = 1'b0;
    if (sum > SINE_HI) begin
      sum = SINE_HI;
      res.saturated = 1'b1;
    end else if (sum < SINE_LO) begin
      sum = SINE_LO;
      res.saturated = 1'b1;
    end
    res.sine = sum[SINE_W-1:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return ANGLE_MAX - ANGLE_W'($urandom_range(0, 255));
      1: return ANGLE_MIN + ANGLE_W'($urandom_range(0, 255));
      2: return ANGLE_W'($urandom_range(0, 4194304)) - ANGLE_W'(2097152);
      default: return ANGLE_W'($urandom());
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] %s", $time, what);
  endtask

  // Requests are taken at an edge where valid and ready are both high. Valid
  // is left high after a request so that back-to-back angles need no gap.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
    int gap;
    gap = idle_enable ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= angle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Every angle gives one result, so an empty queue means an empty pipeline.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_sines.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_term_count(input logic [CNT_W-1:0] count);
    cfg_wdata <= count;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_value();
    send_angle('0);
    send_angle(ANGLE_W'(1));
    send_angle(-ANGLE_W'(1));
    send_angle(ANGLE_MAX);
    send_angle(ANGLE_MIN);
    send_angle(ANGLE_HALF_PI);
    send_angle(-ANGLE_HALF_PI);
    send_angle(ANGLE_ONE);
    send_angle(-ANGLE_ONE);
    send_angle(ANGLE_PI);
    send_angle(-ANGLE_THREE);
  endtask

  // Zero terms and counts above MAX_TERMS are both in this sweep.
  task automatic test_term_count_sweep();
    for (int count = 0; count < 16; count++) begin
      wait_for_results();
      set_term_count(CNT_W'(count));
      send_angle(ANGLE_MAX);
      send_angle(ANGLE_MIN);
      send_angle(ANGLE_ONE);
      repeat (8) send_angle(random_angle());
    end
  endtask

  task automatic test_output_hold();
    wait_for_results();
    set_term_count(CNT_W'(MAX_TERMS));
    idle_enable = 1'b0;
    hold_out = 1'b1;
    repeat (80) send_angle(random_angle());
    wait_for_results();
    idle_enable = 1'b1;
  endtask

  task automatic test_random_phases();
    logic [CNT_W-1:0] count;
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 0)
        count = CNT_W'(MAX_TERMS);
      else if (phase == 1)
        count = '0;
      else
        count = CNT_W'($urandom_range(0, 15));
      wait_for_results();
      set_term_count(count);
      idle_enable = (phase % 3) != 2;
      repeat (100) send_angle(random_angle());
    end
    idle_enable = 1'b1;
  endtask

  // Receiver side: random stalls, or one long hold when a test asks for it.
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
        out_ready <= 1'b1;
      end else begin
        stall = idle_enable ? pick_gap() : 0;
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Predicts on every accepted angle and checks every accepted result.
  always @(posedge clk) begin
    sine_result_t want;
    if (!rst_n) begin
      terms_cfg = TERM_COUNT_RST;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_we) begin
        terms_cfg = cfg_wdata;
        quiet_cycles = 0;
      end
      if (in_valid && in_ready) begin
        expected_sines.push_back(taylor_predict(in_angle, terms_cfg));
        angles_sent++;
        quiet_cycles = 0;
      end
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (expected_sines.size() == 0) begin
          flag_mismatch($sformatf("unexpected result sine=%h", out_sine));
        end else begin
          want = expected_sines.pop_front();
          results_checked++;
          if (out_sine !== want.sine)
            flag_mismatch($sformatf("sine got %h, want %h", out_sine, want.sine));
          if (out_saturated !== want.saturated)
            flag_mismatch($sformatf("saturated got %b, want %b",
                                    out_saturated, want.saturated));
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("[%0t] watchdog: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_value();
    test_term_count_sweep();
    test_output_hold();
    test_random_phases();
    wait_for_results();
    repeat (LATENCY) @(posedge clk);
    if (expected_sines.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_sines.size()));
    $display("Run covered %0d angles and %0d checked results over term counts 0 to 15.",
             angles_sent, results_checked);
    $display("Both channels stalled at random; one long output hold backed up the input.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
